// ===== sv/indexed_ordered_list_engine_defines.svh =====
// assertion macros used by the checker file
`ifndef INDEXED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_ORDERED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define IOLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iole assertion failed");

// next-cycle implication on clk_i, off during reset
`define IOLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iole assertion failed");

`endif

// ===== sv/iole_pkg.sv =====
package iole_pkg;

  // field widths fixed by the interface
  localparam int FUNC_W = 2;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 9;

  // request operations
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_INSERT = 2'd1,
    FN_REMOVE = 2'd2,
    FN_GET    = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // engine states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SHIFT = 2'd1,
    S_GET   = 2'd2
  } state_e;

endpackage

// ===== sv/indexed_ordered_list_engine.sv =====
// Ordered list of up to CAPACITY signed 32-bit values held in one single-port-read,
// single-port-write memory with a registered read. A request is taken when
// start_i is high and busy_o is low; exactly one result follows, shown for one
// cycle with done_o, and the receiver cannot stall it. Timing: a request that
// fails its range or full check is answered in the cycle after it is taken,
// with busy_o staying low. A get keeps busy_o high for one cycle. Append, insert
// and remove move entries one per cycle through the memory (read one entry,
// write it one slot over): busy_o stays high while entries move, and for one
// cycle when none move. At most CAPACITY - 1 entries move. The result appears
// in the same cycle as busy_o falls.
module indexed_ordered_list_engine import iole_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [LEN_W-1:0]         length_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 8) ? CW : 8;

  // control state
  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  left_q, left_d;
  logic           rvalid_q, rvalid_d;
  logic           done_q, done_d;

  // payload registers
  logic              ins_q, ins_d;
  logic [AW-1:0]     src_q, src_d;
  logic [AW-1:0]     dst_q, dst_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] rdata_q;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] rdval_q, rdval_d;
  logic [LEN_W-1:0]  len_q, len_d;

  // memory ports
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] entry_mem [CAPACITY];

  // request decode
  logic          accept;
  logic          full;
  logic          pos_neg;
  logic          in_range;
  logic [CW-1:0] pos_cw;
  logic [CW-1:0] ins_k;
  logic          go_ins, go_rem, go_get, go_err;
  status_e       err_st;
  func_e         func;

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign full    = (cnt_q == CW'(CAPACITY));
  assign pos_neg = position_i[POS_W-1];
  assign pos_cw  = CW'(position_i[POS_W-2:0]);
  assign in_range = !pos_neg &&
                    (CMPW'(position_i[POS_W-2:0]) < CMPW'(cnt_q));
  assign func    = func_e'(func_i);

  // classify the request and pick the insertion slot
  always_comb begin
    go_ins = 1'b0;
    go_rem = 1'b0;
    go_get = 1'b0;
    go_err = 1'b0;
    err_st = ST_OK;
    ins_k  = cnt_q;
    case (func)
      FN_APPEND: begin
        ins_k = cnt_q;
        if (full) begin
          go_err = 1'b1;
          err_st = ST_FULL;
        end else begin
          go_ins = 1'b1;
        end
      end
      FN_INSERT: begin
        ins_k = pos_neg ? '0 : (pos_cw + CW'(1));
        if (!pos_neg && !in_range) begin
          go_err = 1'b1;
          err_st = ST_RANGE;
        end else if (full) begin
          go_err = 1'b1;
          err_st = ST_FULL;
        end else begin
          go_ins = 1'b1;
        end
      end
      FN_REMOVE: begin
        if (!in_range) begin
          go_err = 1'b1;
          err_st = ST_RANGE;
        end else begin
          go_rem = 1'b1;
        end
      end
      FN_GET: begin
        if (!in_range) begin
          go_err = 1'b1;
          err_st = ST_RANGE;
        end else begin
          go_get = 1'b1;
        end
      end
      default: begin
        go_err = 1'b1;
        err_st = ST_RANGE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (go_ins || go_rem)) begin
          state_d = S_SHIFT;
        end else if (accept && go_get) begin
          state_d = S_GET;
        end
      end
      S_SHIFT: begin
        if ((left_q == '0) && !rvalid_q) begin
          state_d = S_IDLE;
        end
      end
      S_GET: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    cnt_d     = cnt_q;
    left_d    = left_q;
    rvalid_d  = 1'b0;
    done_d    = 1'b0;
    ins_d     = ins_q;
    src_d     = src_q;
    dst_d     = dst_q;
    slot_d    = slot_q;
    val_d     = val_q;
    status_d  = status_q;
    rdval_d   = rdval_q;
    len_d     = len_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = dst_q;
    mem_raddr = src_q;
    mem_wdata = rdata_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = value_i;
          if (go_err) begin
            done_d   = 1'b1;
            status_d = err_st;
            rdval_d  = '0;
            len_d    = LEN_W'(cnt_q);
          end else if (go_ins) begin
            // open a gap from the tail down to the slot
            ins_d  = 1'b1;
            slot_d = AW'(ins_k);
            dst_d  = AW'(cnt_q);
            src_d  = AW'(cnt_q - CW'(1));
            left_d = cnt_q - ins_k;
          end else if (go_rem) begin
            // close the gap from the position up to the tail
            ins_d  = 1'b0;
            dst_d  = AW'(pos_cw);
            src_d  = AW'(pos_cw + CW'(1));
            left_d = cnt_q - pos_cw - CW'(1);
          end else if (go_get) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos_cw);
          end
        end
      end
      S_SHIFT: begin
        // issue the next read of the move
        if (left_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = src_q;
          src_d     = ins_q ? (src_q - AW'(1)) : (src_q + AW'(1));
          left_d    = left_q - CW'(1);
        end
        rvalid_d = (left_q != '0);
        // write back the entry read last cycle, or finish
        if (rvalid_q) begin
          mem_we    = 1'b1;
          mem_waddr = dst_q;
          mem_wdata = rdata_q;
          dst_d     = ins_q ? (dst_q - AW'(1)) : (dst_q + AW'(1));
        end else if (left_q == '0) begin
          if (ins_q) begin
            mem_we    = 1'b1;
            mem_waddr = slot_q;
            mem_wdata = val_q;
            cnt_d     = cnt_q + CW'(1);
          end else begin
            cnt_d     = cnt_q - CW'(1);
          end
          done_d   = 1'b1;
          status_d = ST_OK;
          rdval_d  = '0;
          len_d    = LEN_W'(cnt_d);
        end
      end
      S_GET: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        rdval_d  = rdata_q;
        len_d    = LEN_W'(cnt_q);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      left_q   <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      rvalid_q <= rvalid_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ins_q    <= ins_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    slot_q   <= slot_d;
    val_q    <= val_d;
    status_q <= status_d;
    rdval_q  <= rdval_d;
    len_q    <= len_d;
  end

  // entry store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= entry_mem[mem_raddr];
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdval_q;
  assign length_o     = len_q;

endmodule

// ===== sv/iole_checker.sv =====
`include "indexed_ordered_list_engine_defines.svh"

module iole_checker import iole_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic [STAT_W-1:0]        status_o,
  input logic signed [DATA_W-1:0] read_value_o,
  input logic [LEN_W-1:0]         length_o
);

  localparam logic [LEN_W-1:0] FullLen = LEN_W'(CAPACITY);

  // a failed request never returns data
  `IOLE_ASSERT_NOW(a_err_no_data, done_o && (status_o != ST_OK), read_value_o == '0)

  // a taken request either answers at once or starts working
  `IOLE_ASSERT_NEXT(a_accept_progress, start_i && !busy_o, done_o || busy_o)

  // a full answer reports a full list
  `IOLE_ASSERT_NOW(a_full_length, done_o && (status_o == ST_FULL), length_o == FullLen)

  // no result without a request or work behind it
  `IOLE_ASSERT_NOW(a_done_has_cause, done_o, $past(busy_o || start_i))

endmodule

bind indexed_ordered_list_engine iole_checker #(.CAPACITY(CAPACITY)) u_iole_checker (.*);

// ===== tb/indexed_ordered_list_engine_tb.sv =====
module indexed_ordered_list_engine_tb;
  import iole_pkg::*;

  localparam int LIST_DEPTH  = 256;
  localparam int PHASE_ITEMS = 100;
  // sender idle percentage per random phase
  localparam int IDLE_PCT [4] = '{0, 88, 33, 0};

  // one result as the engine reports it
  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [LEN_W-1:0]          length;
  } list_result_t;

  // mirror of the list contents plus the results still owed by the engine
  class list_mirror #(int DEPTH = 256);
    logic signed [DATA_W-1:0] entries [DEPTH];
    int                       count;
    list_result_t             awaited[$];
    int                       errors;
    int                       n_requests;
    int                       n_ok;
    int                       n_range;
    int                       n_full;
    int                       peak;

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // open a slot and fill it, tail entries move one over
    function void place(int slot, logic signed [DATA_W-1:0] val);
      for (int i = count; i > slot; i--) entries[i] = entries[i-1];
      entries[slot] = val;
      count++;
      if (count > peak) peak = count;
    endfunction

    // apply one accepted request and queue the result it must give
    function void note_request(func_e fn, logic signed [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t res;
      int           p;
      bit           in_range;
      bit           full;
      p        = int'(pos);
      in_range = (p >= 0) && (p < count);
      full     = (count >= DEPTH);
      res.status     = ST_OK;
      res.read_value = '0;
      case (fn)
        FN_APPEND: begin
          if (full) res.status = ST_FULL;
          else place(count, val);
        end
        FN_INSERT: begin
          if (p < 0) begin
            if (full) res.status = ST_FULL;
            else place(0, val);
          end else if (!in_range) begin
            res.status = ST_RANGE;
          end else if (full) begin
            res.status = ST_FULL;
          end else begin
            place(p + 1, val);
          end
        end
        FN_REMOVE: begin
          if (!in_range) begin
            res.status = ST_RANGE;
          end else begin
            for (int i = p; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        default: begin
          if (!in_range) res.status = ST_RANGE;
          else res.read_value = entries[p];
        end
      endcase
      res.length = LEN_W'(count);
      n_requests++;
      case (res.status)
        ST_OK:    n_ok++;
        ST_RANGE: n_range++;
        default:  n_full++;
      endcase
      awaited.push_back(res);
    endfunction

    // compare one result with the oldest one owed
    task check_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] rd,
                      logic [LEN_W-1:0] len);
      list_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with no request waiting (status %0d)", st));
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (rd !== want.read_value)
        report($sformatf("read_value %h, want %h", rd, want.read_value));
      if (len !== want.length)
        report($sformatf("length %0d, want %0d", len, want.length));
    endtask
  endclass

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     start_i    = 1'b0;
  logic [FUNC_W-1:0]        func_i     = '0;
  logic signed [POS_W-1:0]  position_i = '0;
  logic signed [DATA_W-1:0] value_i    = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [LEN_W-1:0]         length_o;

  list_mirror #(LIST_DEPTH) mirror = new;

  indexed_ordered_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_value_o(read_value_o),
    .length_o    (length_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // result side, the engine cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) mirror.check_result(status_o, read_value_o, length_o);
  end

  // present one request and hold it until the transfer happens
  task automatic send_request(func_e fn, logic signed [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    start_i    <= 1'b1;
    func_i     <= fn;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    mirror.note_request(fn, pos, val);
  endtask

  // random idle cycles on the request side
  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
  endtask

  // stop sending and wait for every owed result, then let the engine settle
  task automatic drain_results();
    int waited;
    waited  = 0;
    start_i <= 1'b0;
    while (mirror.awaited.size() != 0 && waited < 4 * LIST_DEPTH + 64) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
  endtask

  // mostly valid positions, with edges, negatives and past-the-end ones
  function automatic logic signed [POS_W-1:0] pick_position(int cnt);
    int r;
    r = $urandom_range(99);
    if (r < 8) return POS_W'(-int'($urandom_range(256, 1)));
    if (r < 16 && cnt < LIST_DEPTH) return POS_W'($urandom_range(255, cnt));
    if (cnt == 0) return '0;
    if (r < 24) return '0;
    if (r < 32) return POS_W'(cnt - 1);
    return POS_W'($urandom_range(cnt - 1));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'h8000_0000;
    if (r < 10) return 32'h7fff_ffff;
    if (r < 13) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // growth-heavy mix until the list has filled once, then a balanced mix
  task automatic send_random(bit filling);
    int                      r;
    func_e                   fn;
    logic signed [POS_W-1:0] pos;
    r   = $urandom_range(99);
    pos = pick_position(mirror.count);
    if (filling) begin
      if (r < 48) fn = FN_APPEND;
      else if (r < 88) fn = FN_INSERT;
      else if (r < 94) fn = FN_GET;
      else fn = FN_REMOVE;
    end else if (r < 15) begin
      fn = FN_APPEND;
    end else if (r < 35) begin
      fn = FN_INSERT;
    end else if (r < 70) begin
      fn = FN_REMOVE;
    end else if (r < 92) begin
      fn = FN_GET;
    end else begin
      // noise: any operation at any position
      fn  = func_e'($urandom_range(3));
      pos = POS_W'($urandom_range(511));
    end
    send_request(fn, pos, pick_value());
  endtask

  // stimulus
  initial begin : stimulus
    bit hit_full;
    hit_full = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every position is out of range
    send_request(FN_GET,    0, 0);
    send_request(FN_REMOVE, 0, 0);
    send_request(FN_INSERT, 0, 1);
    send_request(FN_REMOVE, -1, 0);
    // build a short list from both ends
    send_request(FN_APPEND, 0, 32'h7fff_ffff);
    send_request(FN_APPEND, 255, 32'h8000_0000);
    send_request(FN_INSERT, -256, 0);
    send_request(FN_INSERT, 2, -1);
    // insert at or past the count
    send_request(FN_INSERT, 4, 1);
    send_request(FN_INSERT, 255, 1);
    // reads at head, tail, negative and at the count
    send_request(FN_GET, 0, 0);
    send_request(FN_GET, 3, 0);
    send_request(FN_GET, -256, 0);
    send_request(FN_GET, 4, 0);
    send_request(FN_INSERT, 0, 32'h5555_5555);
    send_request(FN_GET, 1, 0);
    // remove at the count and far past it, then head, tail and middle
    send_request(FN_REMOVE, 5, 0);
    send_request(FN_REMOVE, 255, 0);
    send_request(FN_REMOVE, 0, 0);
    send_request(FN_REMOVE, 3, 0);
    send_request(FN_REMOVE, 1, 0);
    send_request(FN_APPEND, -1, 32'haaaa_aaaa);
    send_request(FN_GET, 2, 0);
    drain_results();

    // random phases, each ending with a full drain
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sender_gap(IDLE_PCT[ph]);
        if (mirror.count == LIST_DEPTH) hit_full = 1'b1;
        send_random(!hit_full);
      end
      drain_results();
    end

    if (mirror.awaited.size() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.awaited.size()));
    $display("covered %0d requests: %0d ok, %0d out of range, %0d on a full list",
             mirror.n_requests, mirror.n_ok, mirror.n_range, mirror.n_full);
    $display("longest list %0d of %0d entries, list filled: %0d",
             mirror.peak, LIST_DEPTH, hit_full);
    if (mirror.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("run limit reached with %0d results owed", mirror.awaited.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== indexed_ordered_list_engine.f =====
+incdir+sv
sv/iole_pkg.sv
sv/indexed_ordered_list_engine.sv
sv/iole_checker.sv
tb/indexed_ordered_list_engine_tb.sv
